// ===== rtl/stmf_pkg.sv =====
// ----------------------------------------------------------------------------
// stmf_pkg
// Shared constants, types and helper functions for the sine template
// matched filter: widths, register indexes, controller commands and the
// quarter-wave sine table.
// ----------------------------------------------------------------------------
package stmf_pkg;

  localparam int MAX_TAPS        = 4096;
  localparam int ADDR_W          = $clog2(MAX_TAPS);
  localparam int CNT_W           = ADDR_W + 1;
  localparam int SAMPLE_W        = 16;
  localparam int PHASE_W         = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int OFF_W           = SINE_TABLE_BITS - 2;
  localparam int ROM_DEPTH       = (1 << OFF_W) + 1;
  localparam int ROM_AW          = OFF_W + 1;
  localparam int MAG_W           = 16;
  localparam int SINE_W          = MAG_W + 1;
  localparam int PROD_W          = SAMPLE_W + SINE_W;
  localparam int ACC_W           = PROD_W + ADDR_W;
  localparam int FRAC_SHIFT      = 15;
  localparam int CORR_W          = ACC_W - FRAC_SHIFT;
  localparam int SQ_W            = 2 * CORR_W;
  localparam int VALUE_W         = 56;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int TAP_CFG_W       = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_MODE = 2'd2;

  localparam logic [TAP_CFG_W-1:0] TAP_COUNT_RESET = 13'd1024;

  // controller -> datapath
  typedef struct packed {
    logic start;   // take the input sample, set up the window walk
    logic issue;   // fetch one tap
    logic square;  // register correlation and its square
    logic load;    // move the result into the output register
  } stmf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } stmf_sts_t;

  typedef logic [ROM_DEPTH-1:0][MAG_W-1:0] sine_rom_t;

  // Clamp the tap count to 1..MAX_TAPS.
  function automatic logic [CNT_W-1:0] eff_taps(input logic [TAP_CFG_W-1:0] tc);
    logic [CNT_W-1:0] r;
    if (tc == '0) begin
      r = CNT_W'(1);
    end else if (32'(tc) > MAX_TAPS) begin
      r = CNT_W'(MAX_TAPS);
    end else begin
      r = CNT_W'(tc);
    end
    return r;
  endfunction

  // Quarter-wave magnitude table, Q1.15; evaluated at elaboration only.
  // Angle in Q30, Taylor series in nested form.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t  rom;
    logic [63:0] q;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] m;
    logic [63:0] one;
    one = 64'd1 << 30;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      q = 64'(i) << (30 - OFF_W);
      x = (q * 64'd1686629713) >> 30;
      y = (x * x) >> 30;
      t = one;
      t = one - (((y * t) >> 30) / 64'd110);
      t = one - (((y * t) >> 30) / 64'd72);
      t = one - (((y * t) >> 30) / 64'd42);
      t = one - (((y * t) >> 30) / 64'd20);
      t = one - (((y * t) >> 30) / 64'd6);
      s = (x * t) >> 30;
      m = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      rom[i] = m[MAG_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/stmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// stmf_ctrl
// Sequencer: accepts a sample, walks the taps one per cycle, waits for the
// multiply-accumulate pipe to empty, then hands the result to the output.
// ----------------------------------------------------------------------------
module stmf_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [stmf_pkg::TAP_CFG_W-1:0] tap_count,
  input  stmf_pkg::stmf_sts_t           sts,
  output stmf_pkg::stmf_cmd_t           cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RUN    = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_SQUARE = 3'd3;
  localparam logic [2:0] ST_LOAD   = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic [stmf_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          cnt_nxt   = stmf_pkg::eff_taps(tap_count);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == stmf_pkg::CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/stmf_datapath.sv =====
// ----------------------------------------------------------------------------
// stmf_datapath
// Window memory, template phase generator, sine table, multiply-accumulate
// pipe, correlation scaling and squaring, and the output register.
// ----------------------------------------------------------------------------
module stmf_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  stmf_pkg::stmf_cmd_t                 cmd,
  output stmf_pkg::stmf_sts_t                 sts,
  input  logic signed [stmf_pkg::SAMPLE_W-1:0] sample,
  input  logic [stmf_pkg::PHASE_W-1:0]        phase_step,
  input  logic [stmf_pkg::TAP_CFG_W-1:0]      tap_count,
  input  logic                                energy_mode,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [stmf_pkg::VALUE_W-1:0]        out_value
);

  logic [stmf_pkg::SAMPLE_W-1:0] mem [stmf_pkg::MAX_TAPS];

  logic [stmf_pkg::ADDR_W-1:0]    wp_r;
  logic [stmf_pkg::CNT_W-1:0]     fill_r;
  logic [stmf_pkg::ADDR_W-1:0]    rd_idx_r;
  logic [stmf_pkg::PHASE_W-1:0]   phase_r;
  logic [stmf_pkg::ADDR_W-1:0]    wp_inc;
  logic [stmf_pkg::CNT_W-1:0]     taps;

  logic                           s1_vld_r, s2_vld_r;
  logic signed [stmf_pkg::SAMPLE_W-1:0] rdata_r;
  logic                           slot_ok_r;
  logic [stmf_pkg::MAG_W-1:0]     mag_r;
  logic                           neg_r;
  logic signed [stmf_pkg::PROD_W-1:0] prod_r;
  logic signed [stmf_pkg::ACC_W-1:0]  acc_r;
  logic signed [stmf_pkg::CORR_W-1:0] corr_r;
  logic signed [stmf_pkg::SQ_W-1:0]   sq_r;
  logic                           out_valid_r;
  logic [stmf_pkg::VALUE_W-1:0]   out_value_r;

  logic [stmf_pkg::OFF_W-1:0]     off;
  logic [stmf_pkg::ROM_AW-1:0]    rom_idx;
  logic                           slot_ok;
  logic signed [stmf_pkg::SINE_W-1:0]   sine;
  logic signed [stmf_pkg::SAMPLE_W-1:0] tap_sample;
  logic signed [stmf_pkg::CORR_W-1:0]   corr;

  assign wp_inc = wp_r + 1'b1;
  assign taps   = stmf_pkg::eff_taps(tap_count);

  // odd quadrants read the table mirrored; index 2^OFF_W is the peak
  assign off     = phase_r[stmf_pkg::PHASE_W-3 -: stmf_pkg::OFF_W];
  assign rom_idx = phase_r[stmf_pkg::PHASE_W-2]
                 ? stmf_pkg::ROM_AW'(stmf_pkg::ROM_DEPTH - 1) - {1'b0, off}
                 : {1'b0, off};

  // slots never written since reset read as zero
  assign slot_ok = (fill_r == stmf_pkg::CNT_W'(stmf_pkg::MAX_TAPS)) ||
                   ({1'b0, rd_idx_r} < fill_r);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mem[wp_r] <= sample;
    end
    if (cmd.issue) begin
      rdata_r <= mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else if (cmd.start) begin
      wp_r <= wp_inc;
      if (fill_r != stmf_pkg::CNT_W'(stmf_pkg::MAX_TAPS)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // window walk: oldest sample first, template phase from zero
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_idx_r <= wp_inc - taps[stmf_pkg::ADDR_W-1:0];
      phase_r  <= '0;
    end else if (cmd.issue) begin
      rd_idx_r <= rd_idx_r + 1'b1;
      phase_r  <= phase_r + phase_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      slot_ok_r <= slot_ok;
      mag_r     <= stmf_pkg::SINE_ROM[rom_idx];
      neg_r     <= phase_r[stmf_pkg::PHASE_W-1];
    end
  end

  assign sine       = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
  assign tap_sample = slot_ok_r ? rdata_r : '0;

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      prod_r <= tap_sample * sine;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r <= '0;
    end else if (s2_vld_r) begin
      acc_r <= acc_r + stmf_pkg::ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  // arithmetic shift gives the floor of sum / 2^15
  assign corr = acc_r[stmf_pkg::ACC_W-1:stmf_pkg::FRAC_SHIFT];

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      corr_r <= corr;
      sq_r   <= corr * corr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_value_r <= energy_mode ? sq_r[stmf_pkg::VALUE_W-1:0]
                                 : stmf_pkg::VALUE_W'(corr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.pipe_busy = s1_vld_r | s2_vld_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;

endmodule

// ===== rtl/sine_template_matched_filter_top.sv =====
// ----------------------------------------------------------------------------
// sine_template_matched_filter_top
// Sliding correlator of the input stream against a sine template, with an
// optional squared (energy) output.
// ----------------------------------------------------------------------------
// One result per input sample: the window of the last tap_count samples
// (oldest first) dotted with sin(k * phase_step), floored by 2^15, or
// squared when energy_mode is set. Each sample passes from acceptance to
// the output register through one multiply-accumulate per tap, limited
// by the single read port of the 4096-entry window memory, then pipe
// drain, squaring and output load. A new sample is taken once the
// previous result has moved to the output register, even while that
// result waits for out_tready. The load stalls while an older result
// still waits there. Configuration is to be written while the block is
// idle; the block itself does not enforce this. Window slots not yet
// written since reset read as zero, tracked by a fill count, so no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module sine_template_matched_filter_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // [15:0] sample
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [55:0]                       out_tdata,  // [55:0] value
  input  logic                              cfg_we,
  input  logic [stmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stmf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [stmf_pkg::PHASE_W-1:0]   phase_step_r;
  logic [stmf_pkg::TAP_CFG_W-1:0] tap_count_r;
  logic                           energy_mode_r;

  stmf_pkg::stmf_cmd_t cmd;
  stmf_pkg::stmf_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r  <= '0;
      tap_count_r   <= stmf_pkg::TAP_COUNT_RESET;
      energy_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stmf_pkg::REG_PHASE_STEP:  phase_step_r  <= cfg_wdata;
        stmf_pkg::REG_TAP_COUNT:   tap_count_r   <= cfg_wdata[stmf_pkg::TAP_CFG_W-1:0];
        stmf_pkg::REG_ENERGY_MODE: energy_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  stmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .tap_count (tap_count_r),
    .sts       (sts),
    .cmd       (cmd)
  );

  stmf_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .sample      (in_tdata),
    .phase_step  (phase_step_r),
    .tap_count   (tap_count_r),
    .energy_mode (energy_mode_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_value   (out_tdata)
  );

endmodule
